[hdl/r2fft_pkg.sv]
// shared widths and constants of the radix-2 fft block
package r2fft_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 28;
  localparam int TW_W     = 17;

  localparam int OUT_MAX = 134217727;
  localparam int OUT_MIN = -134217728;

  // pi in q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

endpackage

[hdl/r2fft_twiddle.sv]
// twiddle factor rom, built at elaboration, registered read
module r2fft_twiddle import r2fft_pkg::*; #(
  parameter int POINTS = 1024
) (
  input  logic                                               clk_i,
  input  logic [((POINTS > 2) ? $clog2(POINTS) - 1 : 1)-1:0] idx_i,
  output logic signed [TW_W-1:0]                             w_re_o,
  output logic signed [TW_W-1:0]                             w_im_o
);

  localparam int DEPTH = (POINTS / 2 > 0) ? POINTS / 2 : 1;

  typedef logic [2*TW_W-1:0] tw_tab_t [DEPTH];

  function automatic logic [63:0] mul_rnd(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] div_term(input logic [63:0] t, input int n,
                                           input logic want_sin);
    logic [63:0] r;
    r = '0;
    case (n)
      1: r = want_sin ? t / 64'd6   : t / 64'd2;
      2: r = want_sin ? t / 64'd20  : t / 64'd12;
      3: r = want_sin ? t / 64'd42  : t / 64'd30;
      4: r = want_sin ? t / 64'd72  : t / 64'd56;
      5: r = want_sin ? t / 64'd110 : t / 64'd90;
      6: r = want_sin ? t / 64'd156 : t / 64'd132;
      7: r = want_sin ? t / 64'd210 : t / 64'd182;
      default: r = t;
    endcase
    return r;
  endfunction

  // taylor series in q30, result rounded to q15
  function automatic logic signed [TW_W-1:0] taylor(input logic [63:0] x,
                                                    input logic want_sin);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x2   = mul_rnd(x, x);
    term = want_sin ? x : (64'd1 << 30);
    sum  = signed'(term);
    for (int n = 1; n <= 7; n++) begin
      term = div_term(mul_rnd(term, x2), n, want_sin);
      if (n % 2 == 1) sum = sum - signed'(term);
      else            sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    q = (unsigned'(sum) + 64'd16384) >> 15;
    return TW_W'(q);
  endfunction

  function automatic tw_tab_t gen_table();
    tw_tab_t          t;
    logic [63:0]      j;
    logic [63:0]      m;
    logic [63:0]      x;
    logic             neg_c;
    logic             swap;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    logic signed [TW_W-1:0] tmp;
    for (int k = 0; k < DEPTH; k++) begin
      j     = 64'(k);
      neg_c = 1'b0;
      if (2 * j > 64'(POINTS / 2)) begin
        j     = 64'(POINTS / 2) - j;
        neg_c = 1'b1;
      end
      swap = (8 * j > 64'(POINTS));
      m    = swap ? (64'(POINTS / 4) - j) : j;
      x    = (2 * PI_Q30 * m + 64'(POINTS / 2)) / POINTS;
      c    = taylor(x, 1'b0);
      s    = taylor(x, 1'b1);
      if (swap) begin
        tmp = c;
        c   = s;
        s   = tmp;
      end
      t[k] = {(neg_c ? -c : c), -s};
    end
    return t;
  endfunction

  localparam tw_tab_t TAB = gen_table();

  logic [2*TW_W-1:0] tw_q;

  always_ff @(posedge clk_i) begin
    tw_q <= TAB[idx_i];
  end

  assign w_re_o = signed'(tw_q[2*TW_W-1:TW_W]);
  assign w_im_o = signed'(tw_q[TW_W-1:0]);

endmodule

[hdl/r2fft_bfly.sv]
// two-stage butterfly: rounded complex multiply, then add and subtract
module r2fft_bfly import r2fft_pkg::*; #(
  parameter int WW = 30
) (
  input  logic                   clk_i,
  input  logic signed [WW-1:0]   a_re_i,
  input  logic signed [WW-1:0]   a_im_i,
  input  logic signed [WW-1:0]   b_re_i,
  input  logic signed [WW-1:0]   b_im_i,
  input  logic signed [TW_W-1:0] w_re_i,
  input  logic signed [TW_W-1:0] w_im_i,
  input  logic                   bypass_i,
  output logic signed [WW-1:0]   ya_re_o,
  output logic signed [WW-1:0]   ya_im_o,
  output logic signed [WW-1:0]   yb_re_o,
  output logic signed [WW-1:0]   yb_im_o
);

  localparam int PW = WW + TW_W;
  localparam int RW = WW + 2;
  localparam int SW = WW + 3;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [RW-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [WW-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
  logic signed [SW-1:0] tr, ti;
  logic signed [SW-1:0] sa_re, sa_im, sb_re, sb_im;

  // round half-up from q30 to q15 is an arithmetic shift after the offset
  function automatic logic signed [RW-1:0] rnd15(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p + PW'(16384);
    return RW'(q >>> 15);
  endfunction

  always_comb begin
    p_rr = PW'(b_re_i) * PW'(w_re_i);
    p_ii = PW'(b_im_i) * PW'(w_im_i);
    p_ri = PW'(b_re_i) * PW'(w_im_i);
    p_ir = PW'(b_im_i) * PW'(w_re_i);
  end

  always_ff @(posedge clk_i) begin
    rr_q   <= rnd15(p_rr);
    ii_q   <= rnd15(p_ii);
    ri_q   <= rnd15(p_ri);
    ir_q   <= rnd15(p_ir);
    a_re_q <= a_re_i;
    a_im_q <= a_im_i;
    b_re_q <= b_re_i;
    b_im_q <= b_im_i;
  end

  always_comb begin
    // unit twiddle passes the odd value exactly
    if (bypass_i) begin
      tr = SW'(b_re_q);
      ti = SW'(b_im_q);
    end else begin
      tr = SW'(rr_q) - SW'(ii_q);
      ti = SW'(ri_q) + SW'(ir_q);
    end
    sa_re = SW'(a_re_q) + tr;
    sa_im = SW'(a_im_q) + ti;
    sb_re = SW'(a_re_q) - tr;
    sb_im = SW'(a_im_q) - ti;
  end

  always_ff @(posedge clk_i) begin
    ya_re_o <= sa_re[WW-1:0];
    ya_im_o <= sa_im[WW-1:0];
    yb_re_o <= sb_re[WW-1:0];
    yb_im_o <= sb_im[WW-1:0];
  end

endmodule

[hdl/radix2_fft_real_input_unit.sv]
// top level: sample and bin memories, butterfly sequencer, item channels
//
// Forward radix-2 FFT over POINTS real Q1.15 samples. A push item stores one
// sample; the push that fills the frame starts the transform, and the block
// stalls its input until the transform is done: one butterfly unit is shared
// by every butterfly, and each butterfly runs address, memory read, multiply,
// add and two write states against a work memory with one write port. A read
// item loads the bin read register, and its result moves into the output
// register once that register is empty or not stalled; the next item is taken
// once that result is in the output register. Bins read before the first
// finished frame, or at an index of POINTS or more, come back as zero.
module radix2_fft_real_input_unit import r2fft_pkg::*; #(
  parameter int POINTS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [9:0]              bin_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] bin_real_o,
  output logic signed [OUT_W-1:0] bin_imag_o,
  output logic                    frame_valid_o
);

  localparam int LOG2N = $clog2(POINTS);
  localparam int WW    = SAMPLE_W + LOG2N + 2;
  localparam int SW    = $clog2(LOG2N + 1);
  localparam int TWI_W = (LOG2N > 1) ? LOG2N - 1 : 1;
  localparam int EW    = (WW > OUT_W) ? WW : OUT_W;

  localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_MEM, S_MUL, S_ADD, S_WRA, S_WRB
  } state_e;

  state_e               state_q;
  logic [LOG2N-1:0]     widx_q;
  logic [SW-1:0]        stage_q;
  logic [LOG2N-1:0]     j_q;
  logic [LOG2N-1:0]     a_q, b_q;
  logic [TWI_W-1:0]     tw_idx_q;
  logic                 bypass_q;
  logic                 have_frame_q;
  logic                 pending_q;
  logic                 pend_zero_q;
  logic                 pend_fv_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_re_q, out_im_q;
  logic                 out_fv_q;

  logic                 accept;
  logic [LOG2N-1:0]     half_mask, k_idx, a_addr, b_addr, tw_full;
  logic [SW-1:0]        tw_shift;
  logic                 last_stage, last_j;
  logic [31:0]          idx_ext;
  logic                 in_range;
  logic [LOG2N-1:0]     rd_addr;

  logic [2*WW-1:0]      work_mem [POINTS];
  logic [2*WW-1:0]      rd_a_q, rd_b_q;
  logic                 wr_en;
  logic [LOG2N-1:0]     wr_addr;
  logic [2*WW-1:0]      wr_data;

  logic [2*OUT_W-1:0]   bin_mem [POINTS];
  logic [2*OUT_W-1:0]   bin_rd_q;
  logic                 bin_wr_en;
  logic [LOG2N-1:0]     bin_wr_addr;
  logic [2*OUT_W-1:0]   bin_wr_data;

  logic signed [TW_W-1:0] w_re, w_im;
  logic signed [WW-1:0]   ya_re, ya_im, yb_re, yb_im;

  function automatic logic [LOG2N-1:0] bitrev(input logic [LOG2N-1:0] v);
    logic [LOG2N-1:0] r;
    for (int b = 0; b < LOG2N; b++) r[LOG2N-1-b] = v[b];
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [EW-1:0] e;
    logic [OUT_W-1:0]     r;
    e = EW'(v);
    if (e > SAT_HI)      r = SAT_HI[OUT_W-1:0];
    else if (e < SAT_LO) r = SAT_LO[OUT_W-1:0];
    else                 r = e[OUT_W-1:0];
    return r;
  endfunction

  assign in_stall_o = (state_q != S_IDLE) | pending_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // butterfly addresses for index j within the current stage
  always_comb begin
    half_mask  = (LOG2N'(1) << stage_q) - LOG2N'(1);
    k_idx      = j_q & half_mask;
    a_addr     = ((j_q >> stage_q) << (stage_q + SW'(1))) | k_idx;
    b_addr     = a_addr | (LOG2N'(1) << stage_q);
    tw_shift   = SW'(LOG2N - 1) - stage_q;
    tw_full    = k_idx << tw_shift;
    last_stage = (stage_q == SW'(LOG2N - 1));
    last_j     = (j_q == LOG2N'(POINTS / 2 - 1));
    idx_ext    = 32'(bin_index_i);
    in_range   = idx_ext < 32'(POINTS);
    rd_addr    = idx_ext[LOG2N-1:0];
  end

  // work memory write port: pushes in idle, butterfly results in the write states of all but the last stage
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_q;
    wr_data = {ya_re, ya_im};
    if (state_q == S_IDLE) begin
      wr_en   = accept & ~opcode_i;
      wr_addr = bitrev(widx_q);
      wr_data = {WW'(sample_i), {WW{1'b0}}};
    end else if (state_q == S_WRA) begin
      wr_en = ~last_stage;
    end else if (state_q == S_WRB) begin
      wr_en   = ~last_stage;
      wr_addr = b_q;
      wr_data = {yb_re, yb_im};
    end
  end

  // the last stage writes saturated bins straight into the result store
  always_comb begin
    bin_wr_en   = last_stage & ((state_q == S_WRA) | (state_q == S_WRB));
    bin_wr_addr = (state_q == S_WRB) ? b_q : a_q;
    bin_wr_data = (state_q == S_WRB) ? {sat(yb_re), sat(yb_im)}
                                     : {sat(ya_re), sat(ya_im)};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) work_mem[wr_addr] <= wr_data;
    rd_a_q <= work_mem[a_q];
    rd_b_q <= work_mem[b_q];
  end

  always_ff @(posedge clk_i) begin
    if (bin_wr_en) bin_mem[bin_wr_addr] <= bin_wr_data;
    if (accept & opcode_i) bin_rd_q <= bin_mem[rd_addr];
  end

  r2fft_twiddle #(.POINTS(POINTS)) u_twiddle (
    .clk_i  (clk_i),
    .idx_i  (tw_idx_q),
    .w_re_o (w_re),
    .w_im_o (w_im)
  );

  r2fft_bfly #(.WW(WW)) u_bfly (
    .clk_i    (clk_i),
    .a_re_i   (signed'(rd_a_q[2*WW-1:WW])),
    .a_im_i   (signed'(rd_a_q[WW-1:0])),
    .b_re_i   (signed'(rd_b_q[2*WW-1:WW])),
    .b_im_i   (signed'(rd_b_q[WW-1:0])),
    .w_re_i   (w_re),
    .w_im_i   (w_im),
    .bypass_i (bypass_q),
    .ya_re_o  (ya_re),
    .ya_im_o  (ya_im),
    .yb_re_o  (yb_re),
    .yb_im_o  (yb_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      widx_q       <= '0;
      stage_q      <= '0;
      j_q          <= '0;
      have_frame_q <= 1'b0;
      pending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      a_q          <= '0;
      b_q          <= '0;
      tw_idx_q     <= '0;
      bypass_q     <= 1'b0;
      pend_zero_q  <= 1'b0;
      pend_fv_q    <= 1'b0;
      out_re_q     <= '0;
      out_im_q     <= '0;
      out_fv_q     <= 1'b0;
    end else begin
      // output register
      if (pending_q && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        out_re_q    <= pend_zero_q ? '0 : bin_rd_q[2*OUT_W-1:OUT_W];
        out_im_q    <= pend_zero_q ? '0 : bin_rd_q[OUT_W-1:0];
        out_fv_q    <= pend_fv_q;
        pending_q   <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (opcode_i) begin
              pending_q   <= 1'b1;
              pend_zero_q <= ~in_range | ~have_frame_q;
              pend_fv_q   <= have_frame_q;
            end else if (widx_q == LOG2N'(POINTS - 1)) begin
              widx_q  <= '0;
              stage_q <= '0;
              j_q     <= '0;
              state_q <= S_ADDR;
            end else begin
              widx_q <= widx_q + LOG2N'(1);
            end
          end
        end
        S_ADDR: begin
          a_q      <= a_addr;
          b_q      <= b_addr;
          tw_idx_q <= tw_full[TWI_W-1:0];
          bypass_q <= (k_idx == '0);
          state_q  <= S_MEM;
        end
        S_MEM: state_q <= S_MUL;
        S_MUL: state_q <= S_ADD;
        S_ADD: state_q <= S_WRA;
        S_WRA: state_q <= S_WRB;
        S_WRB: begin
          if (last_j) begin
            j_q <= '0;
            if (last_stage) begin
              have_frame_q <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              stage_q <= stage_q + SW'(1);
              state_q <= S_ADDR;
            end
          end else begin
            j_q     <= j_q + LOG2N'(1);
            state_q <= S_ADDR;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_real_o    = signed'(out_re_q);
  assign bin_imag_o    = signed'(out_im_q);
  assign frame_valid_o = out_fv_q;

endmodule
